>>> hw/rtl/itp_pkg.sv
// itp_pkg: shared constants, types and character helpers for the infix to postfix converter.
// Used by itp_cmp, itp_seq and infix_to_postfix_converter; depends on nothing.
`default_nettype none

package itp_pkg;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int CODE_W          = 3;
   localparam int RES_CNT_W       = 6;
   localparam logic [RES_CNT_W-1:0] RES_MAX = 6'd35;

   // operator codes held on the stack
   localparam logic [CODE_W-1:0] CODE_ADD    = 3'd0;
   localparam logic [CODE_W-1:0] CODE_SUB    = 3'd1;
   localparam logic [CODE_W-1:0] CODE_MUL    = 3'd2;
   localparam logic [CODE_W-1:0] CODE_DIV    = 3'd3;
   localparam logic [CODE_W-1:0] CODE_POW    = 3'd4;
   localparam logic [CODE_W-1:0] CODE_LPAREN = 3'd5;

   // pop test modes of the compare unit
   localparam logic [1:0] MODE_OP    = 2'd0;
   localparam logic [1:0] MODE_RPAR  = 2'd1;
   localparam logic [1:0] MODE_FLUSH = 2'd2;

   // ASCII characters
   localparam logic [7:0] CHR_PLUS  = 8'h2B;
   localparam logic [7:0] CHR_MINUS = 8'h2D;
   localparam logic [7:0] CHR_STAR  = 8'h2A;
   localparam logic [7:0] CHR_SLASH = 8'h2F;
   localparam logic [7:0] CHR_CARET = 8'h5E;
   localparam logic [7:0] CHR_LPAR  = 8'h28;
   localparam logic [7:0] CHR_RPAR  = 8'h29;
   localparam logic [7:0] CHR_DOT   = 8'h2E;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_NUL   = 8'h00;

   typedef struct packed {
      logic [7:0] out_char;
      logic       end_marker;
      logic       overflow_seen;
      logic       invalid_seen;
   } itp_res_type;

   // sequencer to output stage
   typedef struct packed {
      logic        gen_valid;
      logic        done;
      itp_res_type res;
   } itp_gen_type;

   function automatic logic is_operand(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A) || c == CHR_DOT;
   endfunction

   function automatic logic is_operator(input logic [7:0] c);
      return c == CHR_PLUS || c == CHR_MINUS || c == CHR_STAR ||
             c == CHR_SLASH || c == CHR_CARET;
   endfunction

   function automatic logic [CODE_W-1:0] op_code(input logic [7:0] c);
      logic [CODE_W-1:0] code;
      case (c)
         CHR_PLUS:  code = CODE_ADD;
         CHR_MINUS: code = CODE_SUB;
         CHR_STAR:  code = CODE_MUL;
         CHR_SLASH: code = CODE_DIV;
         default:   code = CODE_POW;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] code_char(input logic [CODE_W-1:0] code);
      logic [7:0] c;
      case (code)
         CODE_ADD: c = CHR_PLUS;
         CODE_SUB: c = CHR_MINUS;
         CODE_MUL: c = CHR_STAR;
         CODE_DIV: c = CHR_SLASH;
         CODE_POW: c = CHR_CARET;
         default:  c = CHR_LPAR;
      endcase
      return c;
   endfunction

   function automatic logic [1:0] code_prec(input logic [CODE_W-1:0] code);
      logic [1:0] p;
      case (code)
         CODE_ADD, CODE_SUB: p = 2'd1;
         CODE_MUL, CODE_DIV: p = 2'd2;
         CODE_POW:           p = 2'd3;
         default:            p = 2'd0;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/itp_ram.sv
// itp_ram: generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used by itp_seq for the operator stack.
`default_nettype none

module itp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> hw/rtl/itp_cmp.sv
// itp_cmp: shared pop-test unit, compares the pending operator with the stack top.
// Depends on itp_pkg.
`default_nettype none

module itp_cmp (
   input  wire logic [1:0]                  mode,
   input  wire logic [itp_pkg::CODE_W-1:0]  in_code,
   input  wire logic [itp_pkg::CODE_W-1:0]  top_code,
   input  wire logic                        nonempty,
   output      logic                        pop
);

   always_comb begin
      unique case (mode)
         itp_pkg::MODE_OP: begin
            pop = nonempty &&
                  (itp_pkg::code_prec(in_code) <= itp_pkg::code_prec(top_code));
         end
         itp_pkg::MODE_RPAR: begin
            pop = nonempty && (top_code != itp_pkg::CODE_LPAREN);
         end
         default: begin
            pop = nonempty;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/itp_seq.sv
// itp_seq: per-character sequencer with operator stack, token flags and result counter.
// Depends on itp_pkg, itp_ram and itp_cmp.
`default_nettype none

module itp_seq #(
   parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         req_char,
   input  wire logic               req_last,
   input  wire logic               emit_ok,
   output      logic               idle,
   output      itp_pkg::itp_gen_type gen
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_OPND   = 4'd2;
   localparam logic [3:0] S_TEST   = 4'd3;
   localparam logic [3:0] S_CHAR   = 4'd4;
   localparam logic [3:0] S_WAIT   = 4'd5;
   localparam logic [3:0] S_AFTER  = 4'd6;
   localparam logic [3:0] S_ENDM   = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   logic [3:0]                    state_ff, state_in;
   logic [7:0]                    char_ff, char_in;
   logic                          last_ff, last_in;
   logic [1:0]                    mode_ff, mode_in;
   logic [itp_pkg::CODE_W-1:0]    code_ff, code_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic                          in_operand_ff, in_operand_in;
   logic                          token_ff, token_in;
   logic                          ovf_ff, ovf_in;
   logic                          inv_ff, inv_in;
   logic [itp_pkg::RES_CNT_W-1:0] res_cnt_ff, res_cnt_in;

   logic                          want;
   logic                          under;
   itp_pkg::itp_res_type          gres;
   logic                          wr_en;
   logic [itp_pkg::CODE_W-1:0]    wr_data;
   logic [itp_pkg::CODE_W-1:0]    top_code;
   logic [CNT_W-1:0]              top_ptr;
   logic                          nonempty;
   logic                          room;
   logic                          pop;

   assign top_ptr  = count_ff - CNT_W'(1);
   assign nonempty = (count_ff != '0);
   assign room     = (count_ff < CNT_W'(STACK_DEPTH));
   assign under    = (res_cnt_ff < itp_pkg::RES_MAX);
   assign idle     = (state_ff == S_IDLE);

   itp_ram #(
      .WIDTH (itp_pkg::CODE_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (top_ptr[ADDR_W-1:0]),
      .rd_data (top_code)
   );

   itp_cmp u_cmp (
      .mode     (mode_ff),
      .in_code  (code_ff),
      .top_code (top_code),
      .nonempty (nonempty),
      .pop      (pop)
   );

   always_comb begin
      state_in      = state_ff;
      char_in       = char_ff;
      last_in       = last_ff;
      mode_in       = mode_ff;
      code_in       = code_ff;
      count_in      = count_ff;
      in_operand_in = in_operand_ff;
      token_in      = token_ff;
      ovf_in        = ovf_ff;
      inv_in        = inv_ff;
      res_cnt_in    = res_cnt_ff;
      want          = 1'b0;
      gres          = '{out_char: itp_pkg::CHR_NUL, end_marker: 1'b0,
                        overflow_seen: 1'b0, invalid_seen: 1'b0};
      wr_en         = 1'b0;
      wr_data       = itp_pkg::CODE_LPAREN;
      gen.done      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               char_in    = req_char;
               last_in    = req_last;
               res_cnt_in = '0;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            if (itp_pkg::is_operand(char_ff)) begin
               if (token_ff && !in_operand_ff) begin
                  want          = 1'b1;
                  gres.out_char = itp_pkg::CHR_SPACE;
                  if (emit_ok) begin
                     state_in = S_OPND;
                  end
               end else begin
                  state_in = S_OPND;
               end
            end else begin
               in_operand_in = 1'b0;
               if (char_ff == itp_pkg::CHR_SPACE || char_ff == itp_pkg::CHR_TAB) begin
                  state_in = S_AFTER;
               end else if (itp_pkg::is_operator(char_ff)) begin
                  code_in  = itp_pkg::op_code(char_ff);
                  mode_in  = itp_pkg::MODE_OP;
                  state_in = S_TEST;
               end else if (char_ff == itp_pkg::CHR_LPAR) begin
                  if (room) begin
                     wr_en    = 1'b1;
                     wr_data  = itp_pkg::CODE_LPAREN;
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
                  state_in = S_AFTER;
               end else if (char_ff == itp_pkg::CHR_RPAR) begin
                  mode_in  = itp_pkg::MODE_RPAR;
                  state_in = S_TEST;
               end else begin
                  inv_in   = 1'b1;
                  state_in = S_AFTER;
               end
            end
         end
         S_OPND: begin
            want          = 1'b1;
            gres.out_char = char_ff;
            if (emit_ok) begin
               token_in      = 1'b1;
               in_operand_in = 1'b1;
               state_in      = S_AFTER;
            end
         end
         S_TEST: begin
            if (pop) begin
               if (token_ff) begin
                  want          = 1'b1;
                  gres.out_char = itp_pkg::CHR_SPACE;
                  if (emit_ok) begin
                     state_in = S_CHAR;
                  end
               end else begin
                  state_in = S_CHAR;
               end
            end else begin
               unique case (mode_ff)
                  itp_pkg::MODE_OP: begin
                     if (room) begin
                        wr_en    = 1'b1;
                        wr_data  = code_ff;
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                     state_in = S_AFTER;
                  end
                  itp_pkg::MODE_RPAR: begin
                     // discard the matching '(' if there is one
                     if (nonempty) begin
                        count_in = top_ptr;
                     end
                     state_in = S_AFTER;
                  end
                  default: begin
                     state_in = S_ENDM;
                  end
               endcase
            end
         end
         S_CHAR: begin
            want          = 1'b1;
            gres.out_char = itp_pkg::code_char(top_code);
            if (emit_ok) begin
               count_in = top_ptr;
               token_in = 1'b1;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            // let the stack read catch up with the new top
            state_in = S_TEST;
         end
         S_AFTER: begin
            if (last_ff) begin
               mode_in  = itp_pkg::MODE_FLUSH;
               state_in = S_TEST;
            end else begin
               state_in = S_DONE;
            end
         end
         S_ENDM: begin
            want               = 1'b1;
            gres.out_char      = itp_pkg::CHR_NUL;
            gres.end_marker    = 1'b1;
            gres.overflow_seen = ovf_ff;
            gres.invalid_seen  = inv_ff;
            if (emit_ok) begin
               count_in      = '0;
               in_operand_in = 1'b0;
               token_in      = 1'b0;
               ovf_in        = 1'b0;
               inv_in        = 1'b0;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            gen.done = 1'b1;
            if (emit_ok) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // results past the per-character bound are dropped
      if (want && under && emit_ok) begin
         res_cnt_in = res_cnt_ff + itp_pkg::RES_CNT_W'(1);
      end
      gen.gen_valid = want && under;
      gen.res       = gres;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         in_operand_ff <= 1'b0;
         token_ff      <= 1'b0;
         ovf_ff        <= 1'b0;
         inv_ff        <= 1'b0;
         res_cnt_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         in_operand_ff <= in_operand_in;
         token_ff      <= token_in;
         ovf_ff        <= ovf_in;
         inv_ff        <= inv_in;
         res_cnt_ff    <= res_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      mode_ff <= mode_in;
      code_ff <= code_in;
   end

endmodule

`default_nettype wire

>>> hw/rtl/infix_to_postfix_converter.sv
// infix_to_postfix_converter: top level, request channel, result hold stage and output register.
// Depends on itp_pkg and itp_seq (which uses itp_cmp and itp_ram).
//
// Usage:
//   Request channel (req_): one infix ASCII character per transaction in req_tdata;
//   req_tlast marks the final character of an expression. Result channel (rsp_):
//   postfix characters and single separating spaces in rsp_tdata; rsp_tuser flags
//   the end marker (with the overflow and invalid-character summary). rsp_tlast is
//   set on the last result caused by one request transaction.
//   One character is handled at a time: req_tready is high only while the
//   sequencer is idle. An operator or ')' runs a pop loop around the stack RAM's
//   registered read (test, emit, wait) once for each stack entry popped; an
//   end-of-expression flush runs the same loop for every entry left, then
//   emits the end marker.
//   Results are held one deep so the final one can carry rsp_tlast; a result
//   therefore leaves one result later, or when the character's work completes.
//   A stall holds rsp_tdata, then the sequencer once the hold stage is full; nothing is lost.
//   Reset clears the stack, token state and flags; no clearing pass is needed.
`default_nettype none

module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output      logic       req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_char
   input  wire logic       req_tlast,   // expr_end
   output      logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   output      logic [7:0] rsp_tdata,   // [7:0] out_char
   output      logic [2:0] rsp_tuser,   // [0] end_marker, [1] overflow_seen, [2] invalid_seen
   output      logic       rsp_tlast    // run_last
);

   itp_pkg::itp_gen_type gen;
   logic                 seq_idle;
   logic                 accept;
   logic                 out_free;
   logic                 emit_ok;
   logic                 fire_gen;
   logic                 fire_done;

   // hold stage: one result waiting until we know whether it is the last
   logic                 pend_valid_ff, pend_valid_in;
   itp_pkg::itp_res_type pend_res_ff, pend_res_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   itp_pkg::itp_res_type rsp_res_ff, rsp_res_in;
   logic                 rsp_last_ff, rsp_last_in;

   assign req_tready = seq_idle;
   assign accept     = req_tvalid && req_tready;

   // advance the sequencer only when a produced result has somewhere to go
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit_ok   = !pend_valid_ff || out_free;
   assign fire_gen  = gen.gen_valid && emit_ok;
   assign fire_done = gen.done && emit_ok;

   itp_seq #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_char (req_tdata),
      .req_last (req_tlast),
      .emit_ok  (emit_ok),
      .idle     (seq_idle),
      .gen      (gen)
   );

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_res_in   = pend_res_ff;
      rsp_res_in    = rsp_res_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      if (fire_gen) begin
         // a newer result exists, so the held one is not the last
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_res_in   = pend_res_ff;
            rsp_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_res_in   = gen.res;
      end else if (fire_done) begin
         // character finished: the held result closes the run
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_res_in   = pend_res_ff;
            rsp_last_in  = 1'b1;
         end
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_res_ff <= pend_res_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_res_ff.out_char;
   assign rsp_tuser  = {rsp_res_ff.invalid_seen, rsp_res_ff.overflow_seen,
                        rsp_res_ff.end_marker};
   assign rsp_tlast  = rsp_last_ff;

   // nothing may be left in the hold stage while a new character can be taken
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !pend_valid_ff)
      else $error("result left in hold stage while idle");

   // one character at a time: the block drops ready after an accepted transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request accepted while previous character still in work");

   // the end marker always closes its run and carries a zero character
   a_end_marker_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tlast && rsp_tdata == itp_pkg::CHR_NUL))
      else $error("end marker without run end or with non-zero character");

   // summary flags appear only on the end marker
   a_flags_on_end_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tuser[2:1] == 2'b00))
      else $error("summary flag set on an ordinary result");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// tb_top: self-checking bench for infix_to_postfix_converter, driven by named test tasks.
// Depends on itp_pkg and the converter RTL; predicts every postfix character in-bench.
`timescale 1ns / 100ps

module tb_top;

   localparam int          DEPTH     = itp_pkg::STACK_DEPTH_DEF;
   localparam int          ITEMS     = 470;      // stop random stimulus after this many chars
   localparam int          HOLD_LEN  = 300;      // long receiver hold-off, in cycles
   localparam int          DRAIN     = 200;      // quiet cycles after the last result
   localparam int unsigned LIMIT     = 4000000;  // cycle budget before declaring a hang

   // one postfix character as the result channel should carry it
   typedef struct packed {
      logic [7:0] ch;
      logic       eom;
      logic       ovf;
      logic       inv;
      logic       run_last;
   } postfix_char_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tready = 1'b0;
   wire        req_tready;
   wire        rsp_tvalid;
   wire  [7:0] rsp_tdata;
   wire  [2:0] rsp_tuser;
   wire        rsp_tlast;

   // predictor state: pending operator stack and token bookkeeping
   logic [itp_pkg::CODE_W-1:0] pend_ops [DEPTH];
   int                pend_cnt     = 0;
   bit                in_token     = 1'b0;
   bit                sep_due      = 1'b0;
   bit                saw_overflow = 1'b0;
   bit                saw_invalid  = 1'b0;
   int                step_results;

   postfix_char_type postfix_q [$];

   int          errors        = 0;
   int          items_sent    = 0;
   int unsigned cycles        = 0;
   bit          src_idle_en   = 1'b1;
   bit          sink_idle_en  = 1'b1;
   bit          sink_hold_req = 1'b0;

   infix_to_postfix_converter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Append one character to the expected stream; anything past the
   // per-transaction result bound is dropped, as the block does.
   function automatic void emit(input logic [7:0] ch, input logic eom,
                                input logic ovf, input logic inv);
      postfix_char_type r;
      if (step_results < itp_pkg::RES_MAX) begin
         r = '{ch: ch, eom: eom, ovf: ovf, inv: inv, run_last: 1'b0};
         postfix_q.push_back(r);
         step_results++;
      end
   endfunction

   // Start a new token, with a separating space when one is due.
   function automatic void emit_token(input logic [7:0] ch);
      if (sep_due)
         emit(itp_pkg::CHR_SPACE, 1'b0, 1'b0, 1'b0);
      emit(ch, 1'b0, 1'b0, 1'b0);
      sep_due = 1'b1;
   endfunction

   function automatic logic [1:0] prec_of(input logic [itp_pkg::CODE_W-1:0] code);
      case (code)
         itp_pkg::CODE_ADD, itp_pkg::CODE_SUB: return 2'd1;
         itp_pkg::CODE_MUL, itp_pkg::CODE_DIV: return 2'd2;
         itp_pkg::CODE_POW:                    return 2'd3;
         default:                              return 2'd0;
      endcase
   endfunction

   // Pop the top operator and emit it as its own token.
   function automatic void pop_op();
      logic [7:0] sym;
      pend_cnt--;
      case (pend_ops[pend_cnt])
         itp_pkg::CODE_ADD: sym = itp_pkg::CHR_PLUS;
         itp_pkg::CODE_SUB: sym = itp_pkg::CHR_MINUS;
         itp_pkg::CODE_MUL: sym = itp_pkg::CHR_STAR;
         itp_pkg::CODE_DIV: sym = itp_pkg::CHR_SLASH;
         itp_pkg::CODE_POW: sym = itp_pkg::CHR_CARET;
         default:           sym = itp_pkg::CHR_LPAR;
      endcase
      emit_token(sym);
   endfunction

   // Drop a push onto a full stack and remember that it happened.
   function automatic void push_op(input logic [itp_pkg::CODE_W-1:0] code);
      if (pend_cnt >= DEPTH) begin
         saw_overflow = 1'b1;
      end else begin
         pend_ops[pend_cnt] = code;
         pend_cnt++;
      end
   endfunction

   // Work out every postfix character that one accepted input character causes.
   function automatic void convert_char(input logic [7:0] c, input logic is_last);
      logic [itp_pkg::CODE_W-1:0] code;
      bit                is_op;
      bit                is_operand_ch;
      step_results  = 0;
      is_op         = 1'b1;
      code          = itp_pkg::CODE_ADD;
      is_operand_ch = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                      (c >= "a" && c <= "z") || c == itp_pkg::CHR_DOT;
      case (c)
         itp_pkg::CHR_PLUS:  code = itp_pkg::CODE_ADD;
         itp_pkg::CHR_MINUS: code = itp_pkg::CODE_SUB;
         itp_pkg::CHR_STAR:  code = itp_pkg::CODE_MUL;
         itp_pkg::CHR_SLASH: code = itp_pkg::CODE_DIV;
         itp_pkg::CHR_CARET: code = itp_pkg::CODE_POW;
         default:            is_op = 1'b0;
      endcase

      if (is_operand_ch) begin
         if (in_token)
            emit(c, 1'b0, 1'b0, 1'b0);
         else
            emit_token(c);
         in_token = 1'b1;
      end else begin
         in_token = 1'b0;
         if (c == itp_pkg::CHR_SPACE || c == itp_pkg::CHR_TAB) begin
            // whitespace only closes the current operand
         end else if (is_op) begin
            // equal precedence pops too, which makes '^' left-associative
            while (pend_cnt > 0 && prec_of(code) <= prec_of(pend_ops[pend_cnt-1]))
               pop_op();
            push_op(code);
         end else if (c == itp_pkg::CHR_LPAR) begin
            push_op(itp_pkg::CODE_LPAREN);
         end else if (c == itp_pkg::CHR_RPAR) begin
            // an unmatched ')' empties the stack and discards nothing more
            while (pend_cnt > 0 && pend_ops[pend_cnt-1] != itp_pkg::CODE_LPAREN)
               pop_op();
            if (pend_cnt > 0)
               pend_cnt--;
         end else begin
            saw_invalid = 1'b1;
         end
      end

      if (is_last) begin
         // flush top first, stray '(' included, then the end marker; back to reset state
         while (pend_cnt > 0)
            pop_op();
         emit(itp_pkg::CHR_NUL, 1'b1, saw_overflow, saw_invalid);
         in_token     = 1'b0;
         sep_due      = 1'b0;
         saw_overflow = 1'b0;
         saw_invalid  = 1'b0;
      end

      if (step_results > 0)
         postfix_q[postfix_q.size()-1].run_last = 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offer one character, hold it until accepted, predict, then maybe idle.
   // tvalid stays high when no gap follows, so a back-to-back send never
   // lowers and raises it in one step.
   task automatic send_char(input logic [7:0] c, input logic is_last);
      req_tdata  <= c;
      req_tlast  <= is_last;
      req_tvalid <= 1'b1;
      do
         @(posedge clock);
      while (!req_tready);
      convert_char(c, is_last);
      items_sent++;
      if (src_idle_en && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   // Drop tvalid once the last transaction of a burst has gone, and hold it
   // low for a cycle so the next send starts in a later step.
   task automatic release_req();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_expr(input string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], i == s.len() - 1);
   endtask

   // Build one expression: mostly well formed with random operands, operators,
   // nesting and whitespace; some get a stray byte inserted or a character dropped.
   task automatic send_random_expr();
      logic [7:0] s [$];
      logic [7:0] ops [5] = '{itp_pkg::CHR_PLUS, itp_pkg::CHR_MINUS, itp_pkg::CHR_STAR,
                              itp_pkg::CHR_SLASH, itp_pkg::CHR_CARET};
      int         depth = 0;
      int         terms;
      terms = $urandom_range(1, 6);
      for (int t = 0; t < terms; t++) begin
         if (t > 0)
            s.push_back(ops[$urandom_range(0, 4)]);
         while ($urandom_range(0, 3) == 0 && depth < 20) begin
            s.push_back(itp_pkg::CHR_LPAR);
            depth++;
         end
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 3))
               0:       s.push_back(8'($urandom_range("0", "9")));
               1:       s.push_back(8'($urandom_range("A", "Z")));
               2:       s.push_back(8'($urandom_range("a", "z")));
               default: s.push_back(itp_pkg::CHR_DOT);
            endcase
         end
         while (depth > 0 && $urandom_range(0, 2) == 0) begin
            s.push_back(itp_pkg::CHR_RPAR);
            depth--;
         end
         if ($urandom_range(0, 4) == 0)
            s.push_back($urandom_range(0, 1) ? itp_pkg::CHR_SPACE : itp_pkg::CHR_TAB);
      end
      // close the remaining nesting most of the time
      if ($urandom_range(0, 3) != 0)
         repeat (depth) s.push_back(itp_pkg::CHR_RPAR);
      case ($urandom_range(0, 9))
         0, 1:    s.insert($urandom_range(0, s.size()), 8'($urandom_range(0, 255)));
         2:       if (s.size() > 1) s.delete($urandom_range(0, s.size() - 1));
         default: ;
      endcase
      foreach (s[i])
         send_char(s[i], i == s.size() - 1);
   endtask

   task automatic wait_all_received();
      while (postfix_q.size() != 0)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------

   // Receiver readiness: a long hold-off on request, else random stalls.
   int unsigned sink_gap    = 0;
   int unsigned hold_cycles = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (sink_hold_req) begin
         rsp_tready <= 1'b0;
         hold_cycles++;
         if (hold_cycles >= HOLD_LEN) begin
            hold_cycles   = 0;
            sink_hold_req = 1'b0;
         end
      end else if (sink_gap != 0) begin
         rsp_tready <= 1'b0;
         sink_gap--;
      end else begin
         rsp_tready <= 1'b1;
         if (sink_idle_en && $urandom_range(0, 3) == 0)
            sink_gap = pick_gap();
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("%0t MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
   endtask

   // Compare each result transaction with the oldest prediction.
   always @(posedge clock) begin : result_check
      postfix_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (postfix_q.size() == 0) begin
            report_mismatch("unexpected result, out_char", rsp_tdata, 0);
         end else begin
            want = postfix_q.pop_front();
            if (rsp_tdata !== want.ch)
               report_mismatch("out_char", rsp_tdata, want.ch);
            if (rsp_tuser[0] !== want.eom)
               report_mismatch("end_marker", rsp_tuser[0], want.eom);
            if (rsp_tuser[1] !== want.ovf)
               report_mismatch("overflow_seen", rsp_tuser[1], want.ovf);
            if (rsp_tuser[2] !== want.inv)
               report_mismatch("invalid_seen", rsp_tuser[2], want.inv);
            if (rsp_tlast !== want.run_last)
               report_mismatch("run_last", rsp_tlast, want.run_last);
         end
      end
   end

   // Hang guard.
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Every operator, precedence and left-associative '^', parentheses,
   // whitespace, unknown bytes at both ends of the range, a stray ')',
   // a stray '(' flushed at the end, and an empty expression.
   task automatic test_directed();
      send_expr("A+b*9");
      send_expr("(z-0)^2^c/d");
      send_expr("p)(");
      send_expr("\t");
      send_char(8'hFF, 1'b0);
      send_char("k", 1'b0);
      send_char(8'h00, 1'b1);
      release_req();
   endtask

   // Overfill the stack so the end marker reports it; the closing operand
   // with a separator gives the largest burst a single transaction can cause.
   task automatic test_stack_overflow();
      send_char("a", 1'b0);
      repeat (DEPTH + 1) send_char(itp_pkg::CHR_LPAR, 1'b0);
      send_char("b", 1'b1);
      release_req();
   endtask

   // Hold the receiver off while the sender keeps offering, so the block
   // backs up and stalls its request side.
   task automatic test_sink_holdoff();
      src_idle_en   = 1'b0;
      sink_hold_req = 1'b1;
      repeat (4) send_random_expr();
      release_req();
      src_idle_en = 1'b1;
   endtask

   // Stop sending until every predicted character has arrived, then resume.
   task automatic test_sender_pause();
      send_expr("u*(v+w)^x");
      release_req();
      wait_all_received();
      send_expr("m/n-o");
      release_req();
   endtask

   // Random expressions up to the item budget; some run with no idling at all.
   task automatic test_random_exprs();
      while (items_sent < ITEMS) begin
         if ($urandom_range(0, 5) == 0) begin
            src_idle_en  = 1'b0;
            sink_idle_en = 1'b0;
         end else begin
            src_idle_en  = 1'b1;
            sink_idle_en = 1'b1;
         end
         send_random_expr();
      end
      release_req();
      src_idle_en  = 1'b1;
      sink_idle_en = 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_stack_overflow();
      test_sink_holdoff();
      test_sender_pause();
      test_random_exprs();
      wait_all_received();
      // give any surplus result time to show up
      repeat (DRAIN) @(posedge clock);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
